// File: rtl/tsgd_pkg.sv
// Shared types and constants for the touch swipe gesture detector.
`timescale 1ns / 1ps
`default_nettype none
package tsgd_pkg;

	localparam int TIME_BITS = 32;
	localparam int TIMEOUT_BITS = 16;
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd500;

	localparam logic REG_SWIPE_TIMEOUT = 1'b0;
	localparam logic REG_EVENTS_MUTED = 1'b1;

	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_UP   = 2'd1,
		GEST_DOWN = 2'd2
	} gesture_t;

	typedef enum logic [1:0] {
		PAIR_IDLE   = 2'd0,
		LOWER_FIRST = 2'd1,
		UPPER_FIRST = 2'd2
	} pair_state_t;

	typedef struct packed {
		logic lo;
		logic hi;
		logic prev_lo;
		logic prev_hi;
	} pair_levels_t;

	typedef struct packed {
		logic [TIMEOUT_BITS-1:0] swipe_timeout_ms;
		logic                    events_muted;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/tsgd_cfg.sv
// APB configuration registers of the touch swipe gesture detector.
`timescale 1ns / 1ps
`default_nettype none
module tsgd_cfg import tsgd_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      psel,
	input  wire                      penable,
	input  wire                      pwrite,
	input  wire  [APB_ADDR_BITS-1:0] paddr,
	input  wire  [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	logic [TIMEOUT_BITS-1:0] timeout_q;
	logic                    muted_q;
	logic                    reg_sel;
	logic                    wr_en;

	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			muted_q   <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SWIPE_TIMEOUT: timeout_q <= pwdata[TIMEOUT_BITS-1:0];
				REG_EVENTS_MUTED:  muted_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SWIPE_TIMEOUT: prdata = {{(APB_DATA_BITS-TIMEOUT_BITS){1'b0}}, timeout_q};
			REG_EVENTS_MUTED:  prdata = {{(APB_DATA_BITS-1){1'b0}}, muted_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.swipe_timeout_ms = timeout_q;
	assign cfg.events_muted     = muted_q;

endmodule
`default_nettype wire

// File: rtl/tsgd_pair.sv
// Swipe state and next-state logic for one pad pair.
`timescale 1ns / 1ps
`default_nettype none
module tsgd_pair import tsgd_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     step,
	input  pair_levels_t            levels,
	input  wire  [TIME_BITS-1:0]    now,
	input  wire  [TIMEOUT_BITS-1:0] timeout,
	output gesture_t                gesture
);

	pair_state_t          fp_q;
	pair_state_t          fp_next;
	logic [TIME_BITS-1:0] press_time_q;
	logic [TIME_BITS-1:0] diff;
	logic                 rise_lo;
	logic                 rise_hi;
	logic                 expired;
	logic                 record;

	assign rise_lo = levels.lo && !levels.prev_lo;
	assign rise_hi = levels.hi && !levels.prev_hi;
	assign diff    = now - press_time_q;
	assign expired = diff > TIME_BITS'(timeout);

	always_comb begin
		fp_next = fp_q;
		gesture = GEST_NONE;
		record  = 1'b0;
		if (rise_lo || rise_hi) begin
			case (fp_q)
				PAIR_IDLE: begin
					fp_next = rise_lo ? LOWER_FIRST : UPPER_FIRST;
					record  = 1'b1;
				end
				LOWER_FIRST: begin
					if (expired) begin
						fp_next = PAIR_IDLE;
					end else if (rise_hi) begin
						gesture = GEST_UP;
						fp_next = PAIR_IDLE;
					end
				end
				UPPER_FIRST: begin
					if (expired) begin
						fp_next = PAIR_IDLE;
					end else if (rise_lo) begin
						gesture = GEST_DOWN;
						fp_next = PAIR_IDLE;
					end
				end
				default: fp_next = PAIR_IDLE;
			endcase
		end
		if (!levels.lo && !levels.hi) begin
			fp_next = PAIR_IDLE;
		end
		if (!record && expired) begin
			fp_next = PAIR_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= PAIR_IDLE;
		end else if (step) begin
			fp_q <= fp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (step && record) begin
			press_time_q <= now;
		end
	end

`ifndef SYNTHESIS
	a_gesture_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(step && gesture != GEST_NONE) |-> fp_q != PAIR_IDLE)
		else $error("gesture reported with no pending press");
	a_gesture_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && gesture != GEST_NONE) |=> fp_q == PAIR_IDLE)
		else $error("pair not cleared after gesture");
	a_record_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && record) |-> fp_q == PAIR_IDLE && fp_next != PAIR_IDLE)
		else $error("first press recorded while pending");
`endif

endmodule
`default_nettype wire

// File: rtl/touch_swipe_gesture_detector.sv
// Top level of the touch swipe gesture detector.
// One poll is taken per clock while the input channel is not stalled: a transfer on the
// input channel lands in an input register, both pad pairs are evaluated from it against the
// previous levels, and the two gesture codes are then captured in an output register.
// Throughput is one poll per cycle when no stall holds it, set by the per-pair state update.
// A full output register stalled downstream holds the input register, which stalls the input
// channel. Gestures are muted by register 1; the swipe timeout in ms is register 0 (reset 500).
`timescale 1ns / 1ps
`default_nettype none
module touch_swipe_gesture_detector import tsgd_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      pad1_touched,
	input  wire                      pad2_touched,
	input  wire                      pad3_touched,
	input  wire                      pad4_touched,
	input  wire  [31:0]              time_ms,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic [1:0]               left_gesture,
	output logic [1:0]               right_gesture,
	input  wire                      psel,
	input  wire                      penable,
	input  wire                      pwrite,
	input  wire  [APB_ADDR_BITS-1:0] paddr,
	input  wire  [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t                 cfg;
	logic                 valid_s1;
	logic [3:0]           pads_s1;
	logic [31:0]          time_s1;
	logic [3:0]           prev_levels_q;
	logic                 advance;
	logic                 in_xfer;
	logic [TIME_BITS-1:0] now;
	pair_levels_t         left_levels;
	pair_levels_t         right_levels;
	gesture_t             left_gest;
	gesture_t             right_gest;
	logic                 out_valid_q;
	gesture_t             left_q;
	gesture_t             right_q;

	tsgd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pads_s1 <= {pad4_touched, pad3_touched, pad2_touched, pad1_touched};
			time_s1 <= time_ms;
		end
	end

	assign now = TIME_BITS'(time_s1);

	assign left_levels.lo       = pads_s1[0];
	assign left_levels.hi       = pads_s1[1];
	assign left_levels.prev_lo  = prev_levels_q[0];
	assign left_levels.prev_hi  = prev_levels_q[1];
	assign right_levels.lo      = pads_s1[2];
	assign right_levels.hi      = pads_s1[3];
	assign right_levels.prev_lo = prev_levels_q[2];
	assign right_levels.prev_hi = prev_levels_q[3];

	tsgd_pair u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.levels  (left_levels),
		.now     (now),
		.timeout (cfg.swipe_timeout_ms),
		.gesture (left_gest)
	);

	tsgd_pair u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.levels  (right_levels),
		.now     (now),
		.timeout (cfg.swipe_timeout_ms),
		.gesture (right_gest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				prev_levels_q <= pads_s1;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_q  <= cfg.events_muted ? GEST_NONE : left_gest;
			right_q <= cfg.events_muted ? GEST_NONE : right_gest;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_gesture  = left_q;
	assign right_gesture = right_q;

`ifndef SYNTHESIS
	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped a held poll");
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");
	a_result_follows_poll: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("evaluated poll produced no result");
	a_muted_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg.events_muted) |=> (left_q == GEST_NONE && right_q == GEST_NONE))
		else $error("gesture reported while muted");
`endif

endmodule
`default_nettype wire

// File: tb/touch_swipe_gesture_detector_tb.sv
// Self-checking testbench for the touch swipe gesture detector: directed and random polls against a predictor.
`timescale 1ns / 1ps
module touch_swipe_gesture_detector_tb;
	import tsgd_pkg::*;

	localparam logic [APB_ADDR_BITS-1:0] TIMEOUT_ADDR = {REG_SWIPE_TIMEOUT, 2'b00};
	localparam logic [APB_ADDR_BITS-1:0] MUTE_ADDR = {REG_EVENTS_MUTED, 2'b00};
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [3:0]  pads;
		logic [31:0] stamp;
	} poll_t;

	typedef struct packed {
		gesture_t left;
		gesture_t right;
	} gesture_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic pad1_touched = 1'b0;
	logic pad2_touched = 1'b0;
	logic pad3_touched = 1'b0;
	logic pad4_touched = 1'b0;
	logic [31:0] time_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] left_gesture;
	logic [1:0] right_gesture;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	poll_t poll_queue[$];
	gesture_pair_t expected_gestures[$];
	logic in_took = 1'b0;
	int unsigned idle_pct = 32;
	int unsigned mismatch_count = 0;
	int unsigned stalled_cycles = 0;
	int unsigned polls_made = 0;

	// predictor state and configuration shadow
	logic [TIMEOUT_BITS-1:0] swipe_limit_ms = TIMEOUT_RESET;
	logic gestures_muted = 1'b0;
	logic [3:0] last_levels = '0;
	pair_state_t pending[2] = '{PAIR_IDLE, PAIR_IDLE};
	logic [31:0] press_ms[2] = '{32'd0, 32'd0};

	// stimulus generator state
	logic [3:0] levels = '0;
	logic [31:0] now_ms = '0;

	touch_swipe_gesture_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pad1_touched(pad1_touched),
		.pad2_touched(pad2_touched),
		.pad3_touched(pad3_touched),
		.pad4_touched(pad4_touched),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_gesture(left_gesture),
		.right_gesture(right_gesture),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic gesture_t judge_pair(input int p, input logic lo, input logic hi,
			input logic plo, input logic phi, input logic [31:0] now);
		gesture_t g;
		logic rise_lo;
		logic rise_hi;
		logic [31:0] elapsed;
		g = GEST_NONE;
		rise_lo = lo & ~plo;
		rise_hi = hi & ~phi;
		if (rise_lo || rise_hi) begin
			if (pending[p] == PAIR_IDLE) begin
				pending[p] = rise_lo ? LOWER_FIRST : UPPER_FIRST;
				press_ms[p] = now;
			end else begin
				elapsed = now - press_ms[p];
				if (elapsed <= {16'd0, swipe_limit_ms}) begin
					if (pending[p] == LOWER_FIRST && rise_hi) begin
						g = GEST_UP;
						pending[p] = PAIR_IDLE;
					end else if (pending[p] == UPPER_FIRST && rise_lo) begin
						g = GEST_DOWN;
						pending[p] = PAIR_IDLE;
					end
				end else begin
					pending[p] = PAIR_IDLE;
				end
			end
		end
		if (!lo && !hi)
			pending[p] = PAIR_IDLE;
		elapsed = now - press_ms[p];
		if (pending[p] != PAIR_IDLE && elapsed > {16'd0, swipe_limit_ms})
			pending[p] = PAIR_IDLE;
		return g;
	endfunction

	always @(negedge clk) begin : sender
		poll_t nxt;
		if (arst_n && (!in_valid || in_took)) begin
			if (poll_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = poll_queue.pop_front();
				{pad4_touched, pad3_touched, pad2_touched, pad1_touched} <= nxt.pads;
				time_ms <= nxt.stamp;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin : monitor
		gesture_pair_t want;
		gesture_pair_t result_pair;
		gesture_t lg;
		gesture_t rg;
		logic moved;
		moved = 1'b0;
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (expected_gestures.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected transfer, left %0d right %0d", $time,
					left_gesture, right_gesture);
			end else begin
				want = expected_gestures.pop_front();
				if (left_gesture !== want.left) begin
					mismatch_count++;
					$display("%0t: left_gesture expected %0d got %0d", $time,
						want.left, left_gesture);
				end
				if (right_gesture !== want.right) begin
					mismatch_count++;
					$display("%0t: right_gesture expected %0d got %0d", $time,
						want.right, right_gesture);
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			moved = 1'b1;
			lg = judge_pair(0, pad1_touched, pad2_touched, last_levels[0], last_levels[1],
				time_ms);
			rg = judge_pair(1, pad3_touched, pad4_touched, last_levels[2], last_levels[3],
				time_ms);
			last_levels = {pad4_touched, pad3_touched, pad2_touched, pad1_touched};
			if (gestures_muted) begin
				lg = GEST_NONE;
				rg = GEST_NONE;
			end
			result_pair.left = lg;
			result_pair.right = rg;
			expected_gestures.insert(expected_gestures.size(), result_pair);
		end
		if (moved) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic queue_poll(input logic [3:0] pads, input logic [31:0] stamp);
		poll_t entry;
		entry.pads = pads;
		entry.stamp = stamp;
		poll_queue.insert(poll_queue.size(), entry);
		polls_made++;
	endtask

	function automatic logic [31:0] next_gap();
		int unsigned r;
		logic [31:0] lim;
		lim = {16'd0, swipe_limit_ms};
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(lim);
		if (r < 80)
			return lim + $urandom_range(2) - 1;
		if (r < 95)
			return $urandom_range(lim * 4 + 8);
		return $urandom();
	endfunction

	// advance time, sometimes disturb the other pair, then queue the poll
	task automatic step_poll(input int unsigned p);
		if ($urandom_range(4) == 0)
			levels[2 * (1 - p) +: 2] = 2'($urandom_range(3));
		now_ms = now_ms + next_gap();
		queue_poll(levels, now_ms);
	endtask

	task automatic random_polls(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		int unsigned p;
		int unsigned first_bit;
		int unsigned second_bit;
		target = polls_made + count;
		while (polls_made < target) begin
			pick = $urandom_range(99);
			p = $urandom_range(1);
			if (pick < 65) begin
				first_bit = 2 * p + $urandom_range(1);
				second_bit = first_bit ^ 1;
				levels[2 * p +: 2] = 2'b00;
				if ($urandom_range(2) == 0)
					levels[second_bit] = 1'b1;
				step_poll(p);
				if ($urandom_range(4) == 0)
					levels[2 * p +: 2] = 2'b11;
				else
					levels[first_bit] = 1'b1;
				step_poll(p);
				if ($urandom_range(3) == 0) begin
					levels[first_bit] = 1'b0;
					step_poll(p);
					levels[first_bit] = 1'b1;
					step_poll(p);
				end
				if (levels[second_bit]) begin
					levels[second_bit] = 1'b0;
					step_poll(p);
				end
				levels[second_bit] = 1'b1;
				step_poll(p);
			end else if (pick < 93) begin
				levels = levels ^ 4'($urandom() & $urandom());
				step_poll(p);
			end else begin
				if ($urandom_range(1) == 0)
					now_ms = $urandom();
				else
					now_ms = 32'hFFFF_FFFF - $urandom_range({16'd0, swipe_limit_ms});
				levels = 4'($urandom());
				queue_poll(levels, now_ms);
			end
		end
	endtask

	task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == TIMEOUT_ADDR)
			swipe_limit_ms = value[TIMEOUT_BITS-1:0];
		else if (addr == MUTE_ADDR)
			gestures_muted = value[0];
	endtask

	// wait until every queued poll is sent and every expected transfer has come back
	task automatic drain();
		while (poll_queue.size() != 0 || in_valid || expected_gestures.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: timeout 500, unmuted
		queue_poll(4'b0001, 32'd100);
		queue_poll(4'b0011, 32'd200);
		queue_poll(4'b0000, 32'd210);
		queue_poll(4'b0010, 32'd300);
		queue_poll(4'b0011, 32'd800);
		queue_poll(4'b0000, 32'd810);
		queue_poll(4'b0001, 32'd900);
		queue_poll(4'b0011, 32'd1401);
		queue_poll(4'b0000, 32'd1410);
		queue_poll(4'b1100, 32'd2000);
		queue_poll(4'b0100, 32'd2100);
		queue_poll(4'b1100, 32'd2200);
		queue_poll(4'b0000, 32'd2300);
		queue_poll(4'b0010, 32'd2310);
		queue_poll(4'b0011, 32'd2320);
		queue_poll(4'b0001, 32'd2330);
		queue_poll(4'b0011, 32'd2340);
		queue_poll(4'b0001, 32'd2350);
		queue_poll(4'b0011, 32'd2360);
		queue_poll(4'b0010, 32'd2370);
		queue_poll(4'b0011, 32'd2380);
		queue_poll(4'b0000, 32'hFFFF_FF00);
		queue_poll(4'b1000, 32'hFFFF_FFFF);
		queue_poll(4'b1100, 32'h0000_0010);
		queue_poll(4'b0001, 32'd100);
		queue_poll(4'b0001, 32'd700);
		queue_poll(4'b0011, 32'd710);
		drain();

		write_reg(TIMEOUT_ADDR, 32'd0);
		write_reg(MUTE_ADDR, 32'd0);
		random_polls(200);
		drain();

		write_reg(TIMEOUT_ADDR, 32'd65535);
		random_polls(250);
		drain();

		write_reg(MUTE_ADDR, 32'd1);
		write_reg(TIMEOUT_ADDR, $urandom_range(2000));
		random_polls(250);
		drain();

		write_reg(MUTE_ADDR, 32'd0);
		write_reg(TIMEOUT_ADDR, $urandom_range(300, 1));
		idle_pct = 0;
		random_polls(400);
		drain();
		idle_pct = 32;

		write_reg(TIMEOUT_ADDR, 32'd500);
		random_polls(300);
		drain();

		write_reg(TIMEOUT_ADDR, $urandom());
		write_reg(MUTE_ADDR, $urandom());
		random_polls(300);
		drain();

		if (mismatch_count == 0 && expected_gestures.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
